FILE: sv/bsr_pkg.sv
// Package for the BMP byte stream to RGB565 converter.
// Holds status codes, parse phases, register indexes and header byte positions.
// No dependencies.
package bsr_pkg;

  // Config register file
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SideW   = 13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_BAD_SIG = 3'd1,
    ST_SIZE    = 3'd2,
    ST_PLANES  = 3'd3,
    ST_FORMAT  = 3'd4,
    ST_OFFSET  = 3'd5
  } status_e;

  // Parse phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_PIXELS = 5'b01000,
    PH_PAD    = 5'b10000
  } phase_e;

  // Header byte positions where a field is complete
  localparam logic [31:0] PosSig    = 32'd1;
  localparam logic [31:0] PosOffset = 32'd13;
  localparam logic [31:0] PosWidth  = 32'd21;
  localparam logic [31:0] PosHeight = 32'd25;
  localparam logic [31:0] PosPlanes = 32'd27;
  localparam logic [31:0] PosDepth  = 32'd29;
  localparam logic [31:0] PosLast   = 32'd33;
  localparam logic [31:0] HeaderLen = 32'd34;

  localparam logic [15:0] BmpSignature = 16'h4D42;
  localparam logic [15:0] BitDepth24   = 16'd24;
  localparam logic [15:0] OnePlane     = 16'd1;

  // One result beat from the parser
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [15:0] pixel;
    logic        last;
  } res_t;

endpackage

FILE: sv/bsr_if.sv
// Valid/ready channel interfaces for the BMP to RGB565 converter.
// Depends on bsr_pkg.

// Input byte channel
interface bsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// Result channel
interface bsr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] pixel_value;
  logic        last;
  modport source (output valid, output status, output pixel_value, output last, input ready);
  modport sink   (input valid, input status, input pixel_value, input last, output ready);
endinterface

// Configuration write channel
interface bsr_cfg_if import bsr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [SideW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/bsr_parse.sv
// Header parser and pixel packer: holds the parse state and produces the
// result of the byte presented on each step. Depends on bsr_pkg.
module bsr_parse import bsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             file_start_i,
  input  logic [SideW-1:0] exp_width_i,
  input  logic [SideW-1:0] exp_height_i,
  output res_t             res_o
);

  // Pixel count covers the product of any two size register values
  localparam int unsigned PixW = 2 * SideW;

  logic [31:0]      pos_q, pos_d, pos_e;
  logic [31:0]      fa_q, fa_d, fa_e, fa_n;
  logic [31:0]      off_q, off_d, off_e;
  logic [15:0]      depth_q, depth_d, depth_e;
  phase_e           phase_q, phase_d, phase_e_v;
  logic [10:0]      pp_q, pp_d, pp_e;
  logic [1:0]       bip_q, bip_d, bip_e;
  logic [PixW-1:0]  rem_q, rem_d, rem_e;
  logic [SideW-1:0] roww_q, roww_d;
  logic [SideW-1:0] col_q, col_d, col_e, col_n;
  logic [31:0]      pos_inc;
  logic [2*SideW-1:0] area;
  logic             w_ok, h_ok;
  res_t             res;

  assign area = exp_width_i * exp_height_i;
  assign w_ok = (exp_width_i != '0) && ({19'd0, exp_width_i} <= 32'(MAX_SIDE))
                && ({19'd0, exp_width_i} == fa_n);
  assign h_ok = (exp_height_i != '0) && ({19'd0, exp_height_i} <= 32'(MAX_SIDE))
                && ({19'd0, exp_height_i} == fa_n);
  assign fa_n    = {data_byte_i, fa_e[31:8]};
  assign pos_inc = pos_e + 32'd1;
  assign col_n   = col_e + SideW'(1);

  // File start wipes the file state before the byte is handled
  always_comb begin
    pos_e     = pos_q;
    fa_e      = fa_q;
    off_e     = off_q;
    depth_e   = depth_q;
    pp_e      = pp_q;
    bip_e     = bip_q;
    rem_e     = rem_q;
    col_e     = col_q;
    phase_e_v = phase_q;
    if (file_start_i) begin
      pos_e     = '0;
      fa_e      = '0;
      off_e     = '0;
      depth_e   = '0;
      pp_e      = '0;
      bip_e     = '0;
      rem_e     = '0;
      col_e     = '0;
      phase_e_v = PH_HEADER;
    end
  end

  // Per-byte state update and result
  always_comb begin
    pos_d   = pos_e;
    fa_d    = fa_e;
    off_d   = off_e;
    depth_d = depth_e;
    pp_d    = pp_e;
    bip_d   = bip_e;
    rem_d   = rem_e;
    col_d   = col_e;
    roww_d  = roww_q;
    phase_d = phase_e_v;
    res     = '{valid: 1'b0, status: ST_PIXEL, pixel: 16'd0, last: 1'b0};
    case (phase_e_v)
      PH_HEADER: begin
        fa_d  = fa_n;
        pos_d = pos_inc;
        case (pos_e)
          PosSig: begin
            if (fa_n[31:16] != BmpSignature) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_BAD_SIG, pixel: 16'd0, last: 1'b1};
            end
          end
          PosOffset: off_d = fa_n;
          PosWidth: begin
            if (!w_ok) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_SIZE, pixel: 16'd0, last: 1'b1};
            end
          end
          PosHeight: begin
            if (!h_ok) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_SIZE, pixel: 16'd0, last: 1'b1};
            end
          end
          PosPlanes: begin
            if (fa_n[31:16] != OnePlane) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_PLANES, pixel: 16'd0, last: 1'b1};
            end
          end
          PosDepth: depth_d = fa_n[31:16];
          PosLast: begin
            if (fa_n != '0 || depth_e != BitDepth24) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_FORMAT, pixel: 16'd0, last: 1'b1};
            end else if (off_e < HeaderLen) begin
              phase_d = PH_IDLE;
              res     = '{valid: 1'b1, status: ST_OFFSET, pixel: 16'd0, last: 1'b1};
            end else begin
              roww_d  = exp_width_i;
              col_d   = '0;
              bip_d   = '0;
              pp_d    = '0;
              rem_d   = area[PixW-1:0];
              phase_d = (off_e == HeaderLen) ? PH_PIXELS : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        pos_d = pos_inc;
        if (pos_inc >= off_e) phase_d = PH_PIXELS;
      end
      PH_PIXELS: begin
        case (bip_e)
          2'd0: begin
            pp_d  = {6'd0, data_byte_i[7:3]};
            bip_d = 2'd1;
          end
          2'd1: begin
            pp_d  = {data_byte_i[7:2], pp_e[4:0]};
            bip_d = 2'd2;
          end
          default: begin
            // Red byte closes the pixel; an empty count also ends the image
            bip_d = 2'd0;
            if (rem_e != '0) rem_d = rem_e - PixW'(1);
            res   = '{valid: 1'b1, status: ST_PIXEL,
                      pixel: {data_byte_i[7:3], pp_e}, last: 1'b0};
            if (rem_e <= PixW'(1)) begin
              phase_d  = PH_IDLE;
              res.last = 1'b1;
            end else if (col_n >= roww_q) begin
              col_d = '0;
              if (roww_q[1:0] != 2'd0) begin
                bip_d   = roww_q[1:0];
                phase_d = PH_PAD;
              end
            end else begin
              col_d = col_n;
            end
          end
        endcase
      end
      PH_PAD: begin
        if (bip_e != 2'd0) bip_d = bip_e - 2'd1;
        if (bip_e <= 2'd1) phase_d = PH_PIXELS;
      end
      default: ;
    endcase
  end

  assign res_o = res;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fa_q    <= '0;
      off_q   <= '0;
      depth_q <= '0;
      phase_q <= PH_IDLE;
      pp_q    <= '0;
      bip_q   <= '0;
      rem_q   <= '0;
      roww_q  <= '0;
      col_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      fa_q    <= fa_d;
      off_q   <= off_d;
      depth_q <= depth_d;
      phase_q <= phase_d;
      pp_q    <= pp_d;
      bip_q   <= bip_d;
      rem_q   <= rem_d;
      roww_q  <= roww_d;
      col_q   <= col_d;
    end
  end

endmodule

FILE: sv/bmp_stream_to_rgb565_core.sv
// Top level of the BMP byte stream to RGB565 converter: channel registers,
// size registers and the parser. Depends on bsr_pkg, bsr_if.sv, bsr_parse.
//
// Usage:
//   byte_in_i carries one file byte per beat; file_start marks byte 0 of a
//   file and restarts the parse. res_o carries one beat per finished pixel
//   (status 0) or one beat per rejected header (nonzero status, last set).
//   cfg_i writes the expected width (index 0) and height (index 1); it is
//   always ready and should be used only while no file is in flight.
// Timing:
//   A byte is taken into an input register and handled by the parser while it
//   sits there; its result is then registered in the output register. One
//   byte per cycle sustained, except while a byte that gives a result waits
//   on a held res_o.
// Reset:
//   Parser goes idle and ignores bytes until a file start; sizes return to
//   480 x 320; both channel registers empty.
// Stall:
//   While res_o is held, bytes that give no result keep flowing; a byte that
//   gives a result waits in the input register and byte_in_i drops ready.
module bmp_stream_to_rgb565_core import bsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsr_in_if.sink    byte_in_i,
  bsr_out_if.source res_o,
  bsr_cfg_if.sink   cfg_i
);

  logic             in_v_q;
  logic [7:0]       in_byte_q;
  logic             in_fs_q;
  logic             out_v_q;
  logic [2:0]       out_status_q;
  logic [15:0]      out_pix_q;
  logic             out_last_q;
  logic [SideW-1:0] width_q, height_q;
  logic             out_free, step, in_fire, res_take;
  res_t             res;

  // Size registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(480);
      height_q <= SideW'(320);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_WIDTH)  width_q  <= cfg_i.data;
      if (cfg_i.index == REG_HEIGHT) height_q <= cfg_i.data;
    end
  end

  // Parser
  bsr_parse #(
    .MAX_SIDE (MAX_SIDE)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .file_start_i (in_fs_q),
    .exp_width_i  (width_q),
    .exp_height_i (height_q),
    .res_o        (res)
  );

  // Stage advance: a byte with no result never waits on the output
  assign out_free = !out_v_q || res_o.ready;
  assign step     = in_v_q && (out_free || !res.valid);
  assign res_take = step && res.valid;
  assign byte_in_i.ready = !in_v_q || step;
  assign in_fire  = byte_in_i.valid && byte_in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (byte_in_i.ready) begin
      in_v_q <= byte_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= byte_in_i.data_byte;
      in_fs_q   <= byte_in_i.file_start;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_take) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_status_q <= res.status;
      out_pix_q    <= res.pixel;
      out_last_q   <= res.last;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.status      = out_status_q;
  assign res_o.pixel_value = out_pix_q;
  assign res_o.last        = out_last_q;

  // A result never lands on a beat that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_o.ready) |-> !res_take)
    else $error("result overwrote a held beat");

  // A byte stuck behind a held result stays in the input register
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !step) |=> (in_v_q && $stable(in_byte_q) && $stable(in_fs_q)))
    else $error("input byte lost while stalled");

  // Rejections carry last and a zero pixel
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_take && res.status != ST_PIXEL) |-> (res.last && res.pixel == 16'd0))
    else $error("malformed rejection beat");

  // A stalled result beat holds its payload
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.status)
      && $stable(res_o.pixel_value) && $stable(res_o.last)))
    else $error("result beat changed while stalled");

endmodule

FILE: dv/bsr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the BMP to RGB565 converter: watches the size-register, byte and
// result channels, predicts each result beat and compares it. Depends on bsr_pkg, bsr_if.sv.
module bsr_checker import bsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsr_in_if    byte_i,
  bsr_out_if   res_i,
  bsr_cfg_if   cfg_i,
  output int   err_cnt_o,
  output int   due_cnt_o,
  output int   pix_cnt_o,
  output int   rej_cnt_o
);

  localparam logic [SideW-1:0] ResetWidth  = 13'd480;
  localparam logic [SideW-1:0] ResetHeight = 13'd320;
  localparam int unsigned      RemW        = 2 * SideW;

  typedef struct packed {
    status_e     status;
    logic [15:0] pixel;
    logic        last;
  } rgb_beat_t;

  rgb_beat_t due_q[$];

  // Shadow of the size registers
  logic [SideW-1:0] width_cfg, height_cfg;

  // Parser shadow state
  phase_e           ph_q;
  logic [31:0]      pos_q, shift_q, offset_q;
  logic [15:0]      depth_q, part_q;
  logic [1:0]       sub_q;
  logic [RemW-1:0]  remain_q;
  logic [SideW-1:0] row_w_q, col_q;

  function automatic logic side_ok(input logic [SideW-1:0] cfg, input logic [31:0] seen);
    return cfg >= 1 && cfg <= MAX_SIDE && seen == 32'(cfg);
  endfunction

  task automatic expect_beat(input status_e st, input logic [15:0] pix, input logic lst);
    rgb_beat_t b;
    b.status = st;
    b.pixel  = pix;
    b.last   = lst;
    due_q.push_back(b);
  endtask

  task automatic flag_reject(input status_e st);
    ph_q = PH_IDLE;
    expect_beat(st, 16'h0000, 1'b1);
  endtask

  // Advance the parser by one file byte, queueing any result it produces
  task automatic parse_bmp_byte(input logic [7:0] b, input logic fs);
    logic [31:0] pos;
    if (fs) begin
      pos_q    = '0;
      shift_q  = '0;
      offset_q = '0;
      depth_q  = '0;
      part_q   = '0;
      sub_q    = '0;
      remain_q = '0;
      col_q    = '0;
      ph_q     = PH_HEADER;
    end
    case (ph_q)
      PH_HEADER: begin
        pos     = pos_q;
        shift_q = {b, shift_q[31:8]};
        pos_q   = pos + 32'd1;
        case (pos)
          PosSig:    if (shift_q[31:16] != BmpSignature) flag_reject(ST_BAD_SIG);
          PosOffset: offset_q = shift_q;
          PosWidth:  if (!side_ok(width_cfg, shift_q)) flag_reject(ST_SIZE);
          PosHeight: if (!side_ok(height_cfg, shift_q)) flag_reject(ST_SIZE);
          PosPlanes: if (shift_q[31:16] != OnePlane) flag_reject(ST_PLANES);
          PosDepth:  depth_q = shift_q[31:16];
          PosLast: begin
            if (shift_q != '0 || depth_q != BitDepth24) begin
              flag_reject(ST_FORMAT);
            end else if (offset_q < HeaderLen) begin
              flag_reject(ST_OFFSET);
            end else begin
              row_w_q  = width_cfg;
              col_q    = '0;
              sub_q    = '0;
              part_q   = '0;
              remain_q = RemW'(width_cfg) * RemW'(height_cfg);
              ph_q     = (offset_q == HeaderLen) ? PH_PIXELS : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        pos_q = pos_q + 32'd1;
        if (pos_q >= offset_q) ph_q = PH_PIXELS;
      end
      PH_PIXELS: begin
        // blue, green, red; top bits of each channel kept
        if (sub_q == 2'd0) begin
          part_q = {11'b0, b[7:3]};
          sub_q  = 2'd1;
        end else if (sub_q == 2'd1) begin
          part_q = part_q | {5'b0, b[7:2], 5'b0};
          sub_q  = 2'd2;
        end else begin
          sub_q = 2'd0;
          if (remain_q != '0) remain_q = remain_q - RemW'(1);
          if (remain_q == '0) begin
            ph_q = PH_IDLE;
            expect_beat(ST_PIXEL, {b[7:3], part_q[10:0]}, 1'b1);
          end else begin
            col_q = col_q + SideW'(1);
            if (col_q >= row_w_q) begin
              col_q = '0;
              // row padding: width mod 4 bytes
              if (row_w_q[1:0] != 2'd0) begin
                sub_q = row_w_q[1:0];
                ph_q  = PH_PAD;
              end
            end
            expect_beat(ST_PIXEL, {b[7:3], part_q[10:0]}, 1'b0);
          end
        end
      end
      PH_PAD: begin
        if (sub_q != 2'd0) sub_q = sub_q - 2'd1;
        if (sub_q == 2'd0) ph_q = PH_PIXELS;
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input int want, input int got);
    err_cnt_o++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
  endtask

  // Compare one result beat against the oldest prediction
  task automatic check_beat();
    rgb_beat_t want;
    if (due_q.size() == 0) begin
      err_cnt_o++;
      $display("%0t: result beat with nothing expected, expected none actual %0d/%h/%b",
               $time, res_i.status, res_i.pixel_value, res_i.last);
    end else begin
      want = due_q.pop_front();
      if (res_i.status != want.status) report("status", want.status, res_i.status);
      if (res_i.pixel_value != want.pixel) report("pixel", want.pixel, res_i.pixel_value);
      if (res_i.last != want.last) report("last", want.last, res_i.last);
      if (want.status == ST_PIXEL) pix_cnt_o++;
      else rej_cnt_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      width_cfg  = ResetWidth;
      height_cfg = ResetHeight;
      ph_q       = PH_IDLE;
      pos_q      = '0;
      shift_q    = '0;
      offset_q   = '0;
      depth_q    = '0;
      part_q     = '0;
      sub_q      = '0;
      remain_q   = '0;
      row_w_q    = '0;
      col_q      = '0;
      err_cnt_o  = 0;
      pix_cnt_o  = 0;
      rej_cnt_o  = 0;
      due_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_WIDTH:  width_cfg  = cfg_i.data;
          REG_HEIGHT: height_cfg = cfg_i.data;
          default: ;
        endcase
      end
      if (byte_i.valid && byte_i.ready) parse_bmp_byte(byte_i.data_byte, byte_i.file_start);
      if (res_i.valid && res_i.ready) check_beat();
    end
    due_cnt_o = due_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the BMP to RGB565 converter: clock, reset, file and size-register
// stimulus, result back-pressure and verdict. Depends on bsr_pkg, bsr_if.sv, bsr_checker.
module testbench;
  import bsr_pkg::*;

  localparam int unsigned MaxSide   = 4096;
  localparam int          RandBytes = 400;
  localparam int          LongHold  = 300;

  typedef enum int {
    FL_NONE, FL_SIG, FL_WIDTH, FL_HEIGHT, FL_PLANES, FL_DEPTH, FL_COMP, FL_OFFSET
  } flaw_e;

  logic             clk_i;
  logic             rst_ni;
  logic             tx_idle_on, rx_idle_on, hold_long;
  logic [SideW-1:0] cur_w, cur_h;
  logic [7:0]       file_q[$];
  int               bytes_sent, files_sent, settings;
  int               err_cnt, due_cnt, pix_cnt, rej_cnt;
  flaw_e            flaw;

  bsr_in_if  byte_if ();
  bsr_out_if res_if ();
  bsr_cfg_if cfg_if ();

  bmp_stream_to_rgb565_core #(.MAX_SIDE(MaxSide)) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_if),
    .res_o     (res_if),
    .cfg_i     (cfg_if)
  );

  bsr_checker #(.MAX_SIDE(MaxSide)) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_if),
    .res_i     (res_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (err_cnt),
    .due_cnt_o (due_cnt),
    .pix_cnt_o (pix_cnt),
    .rej_cnt_o (rej_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAIL bmp_stream_to_rgb565_core");
    $finish;
  end

  // Result side: random stalls, plus one long hold on request
  initial begin
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        res_if.ready = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // One byte beat, with an optional idle burst ahead of it
  task automatic push_byte(input logic [7:0] b, input logic fs);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      byte_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    byte_if.valid      = 1'b1;
    byte_if.data_byte  = b;
    byte_if.file_start = fs;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_q[i]) push_byte(file_q[i], i == 0);
    bytes_sent += file_q.size();
    files_sent++;
  endtask

  task automatic send_noise(input int n, input logic with_start);
    repeat (n) push_byte(8'($urandom), with_start && $urandom_range(0, 3) == 0);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) file_q.push_back(v[8*k +: 8]);
  endtask

  task automatic cut_file(input int keep);
    while (file_q.size() > keep) void'(file_q.pop_back());
  endtask

  // Assemble a file: header with one optional flaw, skip gap, then pixel rows
  task automatic build_bmp(input flaw_e fl, input logic [31:0] hw, input logic [31:0] hh,
                           input int gap, input int rows);
    logic [15:0] sig, planes, depth;
    logic [31:0] comp, offset;
    sig    = BmpSignature;
    planes = OnePlane;
    depth  = BitDepth24;
    comp   = '0;
    offset = HeaderLen + gap;
    case (fl)
      FL_SIG:    sig    = BmpSignature ^ 16'($urandom_range(1, 65535));
      FL_WIDTH:  hw     = hw ^ (32'd1 << $urandom_range(0, 31));
      FL_HEIGHT: hh     = hh ^ (32'd1 << $urandom_range(0, 31));
      FL_PLANES: planes = OnePlane ^ 16'($urandom_range(1, 65535));
      FL_DEPTH:  depth  = BitDepth24 ^ 16'($urandom_range(1, 65535));
      FL_COMP:   comp   = 32'($urandom) | (32'd1 << $urandom_range(0, 31));
      FL_OFFSET: offset = $urandom_range(0, HeaderLen - 1);
      default: ;
    endcase
    file_q.delete();
    put_le(32'(sig), 2);
    put_le($urandom, 4);  // file size, unchecked
    put_le($urandom, 4);  // reserved, unchecked
    put_le(offset, 4);
    put_le($urandom, 4);  // DIB size, unchecked
    put_le(hw, 4);
    put_le(hh, 4);
    put_le(32'(planes), 2);
    put_le(32'(depth), 2);
    put_le(comp, 4);
    repeat (gap) file_q.push_back(8'($urandom));
    for (int r = 0; r < rows; r++) begin
      repeat (3 * hw)
        file_q.push_back(($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                      : 8'($urandom));
      repeat (hw[1:0]) file_q.push_back(8'($urandom));
    end
  endtask

  task automatic good_file(input int gap);
    build_bmp(FL_NONE, 32'(cur_w), 32'(cur_h), gap, int'(cur_h));
    send_file();
  endtask

  // Size register write, only once every pending result is out
  task automatic set_side(input reg_idx_e idx, input logic [SideW-1:0] val);
    byte_if.valid = 1'b0;
    while (due_cnt != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    if (idx == REG_WIDTH) cur_w = val;
    else cur_h = val;
  endtask

  task automatic set_size(input int w, input int h);
    set_side(REG_WIDTH, SideW'(w));
    set_side(REG_HEIGHT, SideW'(h));
    settings++;
  endtask

  initial begin
    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.file_start = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_WIDTH;
    cfg_if.data        = '0;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    hold_long          = 1'b0;
    cur_w              = 13'd480;
    cur_h              = 13'd320;
    bytes_sent         = 0;
    files_sent         = 0;
    settings           = 1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Stray bytes while idle, then a bad signature at the reset sizes
    send_noise(3, 1'b0);
    build_bmp(FL_SIG, 32'(cur_w), 32'(cur_h), 0, 0);
    cut_file(4);
    send_file();
    // Full-size header, a few pixels, then a new file cuts in mid-image
    build_bmp(FL_NONE, 32'(cur_w), 32'(cur_h), 2, 1);
    cut_file(HeaderLen + 2 + 13);
    send_file();
    build_bmp(FL_PLANES, 32'(cur_w), 32'(cur_h), 0, 0);
    cut_file(HeaderLen - 6);
    send_file();

    // 1x1 images: all-ones pixel, then one whose kept bits are all zero
    set_size(1, 1);
    build_bmp(FL_NONE, 1, 1, 0, 0);
    repeat (3) file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'hA5);
    send_file();
    build_bmp(FL_NONE, 1, 1, 1, 0);
    file_q.push_back(8'h07);
    file_q.push_back(8'h03);
    file_q.push_back(8'h07);
    send_file();

    // Random files over small sizes; the first ones walk through every flaw
    while (bytes_sent < RandBytes) begin
      if ($urandom_range(0, 3) == 0) set_size($urandom_range(1, 5), $urandom_range(1, 4));
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (files_sent < 6 + FL_OFFSET) flaw = flaw_e'((files_sent - 5) % (FL_OFFSET + 1));
      else if ($urandom_range(0, 1) == 0) flaw = FL_NONE;
      else flaw = flaw_e'($urandom_range(FL_SIG, FL_OFFSET));
      build_bmp(flaw, 32'(cur_w), 32'(cur_h),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0,
                (flaw == FL_NONE) ? int'(cur_h) : 0);
      if ($urandom_range(0, 5) == 0) cut_file($urandom_range(1, file_q.size()));
      send_file();
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6), $urandom_range(0, 1));
    end

    // Long result stall while bytes keep coming
    set_size(7, 7);
    tx_idle_on = 1'b0;
    hold_long  = 1'b1;
    good_file(0);

    // Largest sizes: the start of the widest row, a partial tallest column
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    set_size(MaxSide, 1);
    build_bmp(FL_NONE, 32'(cur_w), 32'(cur_h), 1, 1);
    cut_file(HeaderLen + 1 + 30);
    send_file();
    set_size(1, MaxSide);
    build_bmp(FL_NONE, 32'(cur_w), 32'(cur_h), 0, 10);
    send_file();
    build_bmp(FL_HEIGHT, 32'(cur_w), 32'(cur_h), 0, 0);
    send_file();

    // Out-of-range register values reject every header
    set_size(0, 5);
    build_bmp(FL_NONE, 0, 5, 0, 0);
    send_file();
    set_size(13'h1FFF, 2);
    build_bmp(FL_NONE, 32'h1FFF, 2, 0, 0);
    send_file();
    set_size(3, MaxSide + 1);
    build_bmp(FL_NONE, 3, MaxSide + 1, 0, 0);
    send_file();
    set_size(3, 0);
    build_bmp(FL_NONE, 3, 0, 0, 0);
    send_file();

    // Closing stretch at full rate on both sides
    set_size(3, 2);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    good_file(0);
    build_bmp(FL_COMP, 32'(cur_w), 32'(cur_h), 0, 0);
    send_file();
    good_file(2);

    byte_if.valid = 1'b0;
    while (due_cnt != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Summary: %0d bytes in %0d files across %0d size settings", bytes_sent,
             files_sent, settings);
    $display("Summary: %0d pixel beats and %0d rejection beats compared", pix_cnt, rej_cnt);
    if (err_cnt == 0) begin
      $display("PASS bmp_stream_to_rgb565_core");
    end else begin
      $display("FAIL bmp_stream_to_rgb565_core");
    end
    $finish;
  end

endmodule
